### sv/sacl_pkg.sv
`timescale 1ns / 1ps
// shared constants, status codes and controller/datapath struct types
// for the sample autocorrelation core; depends on nothing
package sacl_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_LAG         = 64;

	localparam int IN_W       = 16;
	localparam int LAG_W      = 7;
	localparam int MIN_LAG_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int RATIO_W    = 17;
	localparam int Q_FRAC     = 15;
	localparam int QUOT_W     = Q_FRAC + 1;
	localparam int STATUS_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG = 1'b1;

	localparam logic [MIN_LAG_W-1:0] MIN_LAG_RST = 6'd1;
	localparam logic [LAG_W-1:0]     MAX_LAG_RST = 7'd16;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CFG  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

	typedef struct packed {
		logic             sample_we;
		logic             series_clr;
		logic             mac_clr;
		logic             issue;
		logic             zl_load;
		logic             div_start;
		logic             emit;
		logic             emit_err;
		logic             ratio_div;
		logic             last;
		logic [LAG_W-1:0] lag;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pair_ok;
		logic lag_ok;
		logic zl_zero;
		logic mac_busy;
		logic div_done;
	} dp_stat_t;

endpackage

### sv/sacl_ram.sv
`timescale 1ns / 1ps
// generic single-write, dual-read ram with registered read data
// depends on sacl_pkg for default sizes
module sacl_ram #(
	parameter int WIDTH = sacl_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = sacl_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                       rdata_a,
	output logic [WIDTH-1:0]                       rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

### sv/sacl_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle, for the q1.15 ratio
// depends on sacl_pkg for the quotient width
module sacl_div #(
	parameter int ACC_W = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [ACC_W-1:0]        num,
	input  logic [ACC_W-1:0]               den,
	output logic                           done,
	output logic [sacl_pkg::QUOT_W-1:0]    quot,
	output logic                           neg
);

	localparam int QW     = sacl_pkg::QUOT_W;
	localparam int STEP_W = $clog2(QW + 1);

	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  den_q;
	logic [QW-1:0]     quot_q;
	logic              neg_q;
	logic              run_q;
	logic              first_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;

	logic [ACC_W-1:0] abs_num;
	logic [ACC_W-1:0] rem_sh;
	logic             ge;
	logic [ACC_W-1:0] rem_nx;

	// |num| never exceeds den, so the first step yields the integer bit
	assign abs_num = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
	assign rem_sh  = first_q ? rem_q : {rem_q[ACC_W-2:0], 1'b0};
	assign ge      = (rem_sh >= den_q);
	assign rem_nx  = ge ? (rem_sh - den_q) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= run_q && (step_q == STEP_W'(1));
			if (start) begin
				run_q   <= 1'b1;
				first_q <= 1'b1;
				step_q  <= STEP_W'(QW);
			end else if (run_q) begin
				first_q <= 1'b0;
				step_q  <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= abs_num;
			den_q  <= den;
			quot_q <= '0;
			neg_q  <= num[ACC_W-1];
		end else if (run_q) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign neg  = neg_q;

endmodule

### sv/sacl_dp.sv
`timescale 1ns / 1ps
// datapath: sample store, count and sum, centred multiply-accumulate,
// divider and result registers; depends on sacl_pkg, sacl_ram, sacl_div
module sacl_dp #(
	parameter int MAX_SAMPLES = sacl_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sacl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sacl_pkg::ctrl_cmd_t                  cmd,
	output sacl_pkg::dp_stat_t                   stat,
	input  logic signed [sacl_pkg::IN_W-1:0]     sample,
	output logic                                 result_valid,
	output logic [sacl_pkg::LAG_W-1:0]           lag,
	output logic signed [sacl_pkg::RATIO_W-1:0]  ratio,
	output logic [sacl_pkg::STATUS_W-1:0]        status,
	output logic                                 last_result
);

	localparam int LAG_W   = sacl_pkg::LAG_W;
	localparam int RATIO_W = sacl_pkg::RATIO_W;
	localparam int AW      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W   = SAMPLE_BITS + AW;
	localparam int D_W     = SUM_W + 1;
	localparam int NX_W    = CNT_W + 1 + SAMPLE_BITS;
	localparam int P_W     = 2 * D_W;
	localparam int ACC_W   = P_W + AW;
	localparam int IK_W    = ((CNT_W > LAG_W) ? CNT_W : LAG_W) + 1;

	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    ovf_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    v_s0;
	logic                    v_s1;
	logic                    v_s2;
	logic signed [D_W-1:0]   d_a_s1;
	logic signed [D_W-1:0]   d_b_s1;
	logic signed [P_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] zl_q;

	logic                          res_valid_q;
	logic [LAG_W-1:0]              lag_q;
	logic [RATIO_W-1:0]            ratio_q;
	logic [sacl_pkg::STATUS_W-1:0] status_q;
	logic                          last_q;

	logic signed [SAMPLE_BITS-1:0] sx;
	logic                          full;
	logic                          ram_we;
	logic [IK_W-1:0]               ik;
	logic [SAMPLE_BITS-1:0]        rd_a;
	logic [SAMPLE_BITS-1:0]        rd_b;
	logic signed [NX_W-1:0]        cen_a;
	logic signed [NX_W-1:0]        cen_b;
	logic                          div_done;
	logic [sacl_pkg::QUOT_W-1:0]   quot;
	logic                          quot_neg;
	logic [RATIO_W-1:0]            q_ext;
	logic [RATIO_W-1:0]            div_ratio;
	logic [sacl_pkg::STATUS_W-1:0] run_status;

	assign sx     = sample[SAMPLE_BITS-1:0];
	assign full   = (cnt_q == CNT_W'(MAX_SAMPLES));
	assign ram_we = cmd.sample_we && !full;
	assign ik     = IK_W'(idx_q) + IK_W'(cmd.lag);

	sacl_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cnt_q[AW-1:0]),
		.wdata   (sample[SAMPLE_BITS-1:0]),
		.raddr_a (idx_q[AW-1:0]),
		.raddr_b (ik[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// series state: count, running sum and the dropped-sample flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.series_clr) begin
			cnt_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.sample_we) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(sx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s0  <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s0 <= cmd.issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			if (cmd.mac_clr) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// centring: N*x - S, exact and scaled by N
	assign cen_a = NX_W'($signed({1'b0, cnt_q})) * NX_W'($signed(rd_a)) - NX_W'(sum_q);
	assign cen_b = NX_W'($signed({1'b0, cnt_q})) * NX_W'($signed(rd_b)) - NX_W'(sum_q);

	always_ff @(posedge clk) begin
		d_a_s1  <= cen_a[D_W-1:0];
		d_b_s1  <= cen_b[D_W-1:0];
		prod_s2 <= P_W'(d_a_s1) * P_W'(d_b_s1);
		if (cmd.mac_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.zl_load) begin
			zl_q <= acc_q;
		end
	end

	sacl_div #(
		.ACC_W (ACC_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (acc_q),
		.den    (zl_q),
		.done   (div_done),
		.quot   (quot),
		.neg    (quot_neg)
	);

	assign q_ext     = RATIO_W'(quot);
	assign div_ratio = quot_neg ? (~q_ext + RATIO_W'(1)) : q_ext;

	always_comb begin
		if (cmd.emit_err) begin
			run_status = sacl_pkg::ST_BAD_CFG;
		end else if (zl_q == '0) begin
			run_status = sacl_pkg::ST_ZERO_VAR;
		end else if (ovf_q) begin
			run_status = sacl_pkg::ST_DROPPED;
		end else begin
			run_status = sacl_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			lag_q    <= cmd.emit_err ? '0 : cmd.lag;
			ratio_q  <= cmd.ratio_div ? div_ratio : '0;
			status_q <= run_status;
			last_q   <= cmd.last;
		end
	end

	assign stat.pair_ok  = (ik < IK_W'(cnt_q));
	assign stat.lag_ok   = (IK_W'(cmd.lag) < IK_W'(cnt_q));
	assign stat.zl_zero  = (zl_q == '0);
	assign stat.mac_busy = v_s0 || v_s1 || v_s2;
	assign stat.div_done = div_done;

	assign result_valid = res_valid_q;
	assign lag          = lag_q;
	assign ratio        = ratio_q;
	assign status       = status_q;
	assign last_result  = last_q;

`ifndef SYNTHESIS
	a_zl_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.zl_load |-> !stat.mac_busy)
		else $error("lag-0 value taken with products still in flight");

	a_div_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.mac_busy)
		else $error("division started before the lag sum was complete");

	a_clr_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_clr |-> !v_s2)
		else $error("accumulator cleared while a product was arriving");
`endif

endmodule

### sv/sacl_ctrl.sv
`timescale 1ns / 1ps
// controller: lag registers and the state machine that sequences the
// lag-0 pass, each lag pass, division and emission; depends on sacl_pkg
module sacl_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              last_sample,
	input  logic                              cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  sacl_pkg::dp_stat_t                stat,
	output sacl_pkg::ctrl_cmd_t               cmd,
	output logic                              busy
);

	localparam int LAG_W     = sacl_pkg::LAG_W;
	localparam int MIN_LAG_W = sacl_pkg::MIN_LAG_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MAC   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DIV   = 4'b1000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [LAG_W-1:0]     k_q;
	logic [LAG_W-1:0]     k_d;
	logic [MIN_LAG_W-1:0] min_q;
	logic [LAG_W-1:0]     max_q;
	logic                 bad_cfg;
	logic                 at_max;
	logic                 next_lag;

	assign bad_cfg = (min_q == '0) || (max_q > LAG_W'(sacl_pkg::MAX_LAG)) ||
		(LAG_W'(min_q) >= max_q);
	assign at_max  = (k_q == max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= sacl_pkg::MIN_LAG_RST;
			max_q <= sacl_pkg::MAX_LAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sacl_pkg::CFG_MIN_LAG: begin
					min_q <= cfg_data[MIN_LAG_W-1:0];
				end
				sacl_pkg::CFG_MAX_LAG: begin
					max_q <= cfg_data[LAG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		next_lag      = 1'b0;
		state_d       = state_q;
		k_d           = k_q;
		cmd           = '0;
		cmd.lag       = k_q;
		cmd.last      = at_max;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.sample_we = 1'b1;
					if (last_sample) begin
						if (bad_cfg) begin
							cmd.emit       = 1'b1;
							cmd.emit_err   = 1'b1;
							cmd.last       = 1'b1;
							cmd.series_clr = 1'b1;
						end else begin
							cmd.mac_clr = 1'b1;
							k_d         = '0;
							state_d     = S_MAC;
						end
					end
				end
			end
			S_MAC: begin
				if (stat.pair_ok) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.mac_busy) begin
					if (k_q == '0) begin
						// lag-0 pass finished: keep it as the denominator
						cmd.zl_load = 1'b1;
						cmd.mac_clr = 1'b1;
						k_d         = LAG_W'(min_q);
						state_d     = S_MAC;
					end else if (stat.lag_ok && !stat.zl_zero) begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end else begin
						cmd.emit = 1'b1;
						next_lag = 1'b1;
					end
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.emit      = 1'b1;
					cmd.ratio_div = 1'b1;
					next_lag      = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (next_lag) begin
			if (at_max) begin
				cmd.series_clr = 1'b1;
				state_d        = S_IDLE;
			end else begin
				k_d         = k_q + LAG_W'(1);
				cmd.mac_clr = 1'b1;
				state_d     = S_MAC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == S_IDLE))
		else $error("run did not end after its final word");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(cmd.emit && cmd.last))
		else $error("busy dropped without a final word");
`endif

endmodule

### sv/sample_autocorrelation_lags_core.sv
`timescale 1ns / 1ps
// Sample autocorrelation core. Inputs: start/busy command channel carrying
// sample and last_sample; a word is taken on a clock edge with start high and
// busy low. Samples that are not last are stored, counted and summed, and
// busy stays low, so one can follow every cycle. Past the store depth a
// sample is dropped and the run is flagged.
// On the last sample the block goes busy: a lag-0 pass, then for each lag k
// from min_lag to max_lag one pass of the single multiply-accumulate pipe
// over the store's two read ports and, when k is below the sample count and
// the lag-0 sum is nonzero, a restoring division.
// Each result word appears on lag/ratio/status/last_result for exactly one
// cycle with result_valid high; the receiver cannot stall, and the last
// word carries last_result. A bad lag setting yields one error word the
// cycle after the last sample, without going busy. min_lag and max_lag are
// written through cfg_we/cfg_index/cfg_data, by the user only while idle;
// the block does not enforce it. Reset (arst_n low) clears the series and
// loads min_lag 1, max_lag 16; the sample store needs no clearing pass.
module sample_autocorrelation_lags_core #(
	parameter int MAX_SAMPLES = sacl_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sacl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [sacl_pkg::IN_W-1:0]     sample,
	input  logic                                 last_sample,
	input  logic                                 cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 result_valid,
	output logic [sacl_pkg::LAG_W-1:0]           lag,
	output logic signed [sacl_pkg::RATIO_W-1:0]  ratio,
	output logic [sacl_pkg::STATUS_W-1:0]        status,
	output logic                                 last_result
);

	sacl_pkg::ctrl_cmd_t cmd;
	sacl_pkg::dp_stat_t  stat;

	sacl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_sample (last_sample),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	sacl_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.result_valid (result_valid),
		.lag          (lag),
		.ratio        (ratio),
		.status       (status),
		.last_result  (last_result)
	);

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// testbench for sample_autocorrelation_lags_core: directed and random
// sample series, each result word checked against an in-bench autocorrelation predictor
// depends on sacl_pkg and the core only
module tb;

	localparam int IN_W       = sacl_pkg::IN_W;
	localparam int LAG_W      = sacl_pkg::LAG_W;
	localparam int MIN_LAG_W  = sacl_pkg::MIN_LAG_W;
	localparam int RATIO_W    = sacl_pkg::RATIO_W;
	localparam int STATUS_W   = sacl_pkg::STATUS_W;
	localparam int CFG_IDX_W  = sacl_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = sacl_pkg::CFG_DATA_W;
	localparam int Q_FRAC     = sacl_pkg::Q_FRAC;
	localparam int MAX_LAG    = sacl_pkg::MAX_LAG;

	localparam int CAPACITY   = sacl_pkg::MAX_SAMPLES_DEF;
	localparam int RAND_ITEMS = 60;
	localparam int SETTLE     = 40;
	localparam int WATCHDOG   = 20000;

	typedef logic signed [IN_W-1:0] sample_t;

	typedef enum int {SER_FULL, SER_SMALL, SER_CONST, SER_EXTREME} series_kind_t;

	typedef struct {
		logic [LAG_W-1:0]           lag;
		logic signed [RATIO_W-1:0]  ratio;
		logic [STATUS_W-1:0]        st;
		logic                       last;
	} lag_result_t;

	class acf_scoreboard;
		sample_t          store [CAPACITY];
		int               count;
		longint           sum;
		bit               dropped;
		logic [MIN_LAG_W-1:0] min_lag;
		logic [LAG_W-1:0] max_lag;
		lag_result_t      expected [$];
		int               mismatches;

		function new();
			count = 0;
			sum = 0;
			dropped = 0;
			min_lag = sacl_pkg::MIN_LAG_RST;
			max_lag = sacl_pkg::MAX_LAG_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			if (idx == sacl_pkg::CFG_MIN_LAG)
				min_lag = v[MIN_LAG_W-1:0];
			else
				max_lag = v;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// N*x - S, exact centring scaled by the count
		function longint centred(int i);
			return longint'(count) * longint'(store[i]) - sum;
		endfunction

		function longint lag_sum(int k);
			longint acc;
			acc = 0;
			for (int i = 0; i + k < count; i++)
				acc += centred(i) * centred(i + k);
			return acc;
		endfunction

		// num * 2^15 / den, truncated toward zero; |num| <= den
		function logic signed [RATIO_W-1:0] q15_of(longint num, longint den);
			logic [79:0] mag;
			logic [79:0] q;
			logic signed [RATIO_W-1:0] r;
			mag = (num < 0) ? 80'(-num) : 80'(num);
			q = (mag << Q_FRAC) / 80'(den);
			r = RATIO_W'(q);
			if (num < 0)
				r = -r;
			return r;
		endfunction

		function void clear_series();
			count = 0;
			sum = 0;
			dropped = 0;
		endfunction

		function void note_sample(sample_t s, logic fin);
			lag_result_t w;
			longint zl;
			logic [STATUS_W-1:0] st;
			if (count < CAPACITY) begin
				store[count] = s;
				count++;
				sum += longint'(s);
			end else begin
				dropped = 1;
			end
			if (!fin)
				return;
			if (min_lag == 0 || max_lag > MAX_LAG || int'(min_lag) >= int'(max_lag)) begin
				w.lag = '0;
				w.ratio = '0;
				w.st = sacl_pkg::ST_BAD_CFG;
				w.last = 1'b1;
				expected.push_back(w);
				clear_series();
				return;
			end
			zl = lag_sum(0);
			if (zl == 0)
				st = sacl_pkg::ST_ZERO_VAR;
			else if (dropped)
				st = sacl_pkg::ST_DROPPED;
			else
				st = sacl_pkg::ST_OK;
			for (int k = int'(min_lag); k <= int'(max_lag); k++) begin
				w.lag = LAG_W'(k);
				w.ratio = (zl != 0 && k < count) ? q15_of(lag_sum(k), zl) : '0;
				w.st = st;
				w.last = (k == int'(max_lag));
				expected.push_back(w);
			end
			clear_series();
		endfunction

		function void note_error(string msg);
			if (mismatches < 10)
				$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endfunction

		function void check_result(logic [LAG_W-1:0] l, logic signed [RATIO_W-1:0] r,
		                           logic [STATUS_W-1:0] s, logic fin);
			lag_result_t want;
			if (expected.size() == 0) begin
				note_error($sformatf("unexpected word lag %0d ratio %0d status %0d last %0d",
				                     l, r, s, fin));
				return;
			end
			want = expected.pop_front();
			if (want.lag !== l || want.ratio !== r || want.st !== s || want.last !== fin)
				note_error($sformatf({"expected lag %0d ratio %0d status %0d last %0d, ",
				                      "got lag %0d ratio %0d status %0d last %0d"},
				                     want.lag, want.ratio, want.st, want.last, l, r, s, fin));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	sample_t                    sample;
	logic                       last_sample;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       result_valid;
	logic [LAG_W-1:0]           lag;
	logic signed [RATIO_W-1:0]  ratio;
	logic [STATUS_W-1:0]        status;
	logic                       last_result;

	acf_scoreboard sb;
	int idle_cycles = 0;

	sample_autocorrelation_lags_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample       (sample),
		.last_sample  (last_sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.lag          (lag),
		.ratio        (ratio),
		.status       (status),
		.last_result  (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(lag, ratio, status, last_result);
	end

	// no word moved in either direction for too long means the core is stuck
	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic sample_t pick_sample(series_kind_t kind, sample_t base);
		case (kind)
		SER_FULL:  return sample_t'($urandom);
		SER_SMALL: return sample_t'($urandom_range(0, 400)) - sample_t'(200);
		SER_CONST: return base;
		default: begin
			case ($urandom_range(0, 4))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return sample_t'($urandom);
			endcase
		end
		endcase
	endfunction

	task automatic gap(int n);
		if (n == 0)
			return;
		@(negedge clk);
		start <= 1'b0;
		sample <= sample_t'($urandom);
		last_sample <= 1'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_word(sample_t s, logic fin);
		@(negedge clk);
		start <= 1'b1;
		sample <= s;
		last_sample <= fin;
		do @(posedge clk); while (busy);
		sb.note_sample(s, fin);
	endtask

	task automatic send_vals(input sample_t vals[$]);
		foreach (vals[i]) begin
			gap(gap_len());
			send_word(vals[i], i == vals.size() - 1);
		end
	endtask

	task automatic send_series(int len, series_kind_t kind, bit burst);
		sample_t base;
		base = sample_t'($urandom);
		for (int i = 0; i < len; i++) begin
			if (!burst)
				gap(gap_len());
			send_word(pick_sample(kind, base), i == len - 1);
		end
	endtask

	task automatic wait_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// after the final word the core may still be winding down
	task automatic wait_idle();
		wait_results();
		while (busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	initial begin
		sample_t dir [$];
		int lo;
		int hi;
		int len;
		int sent;
		bit burst;
		series_kind_t kind;

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		last_sample = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sacl_pkg::CFG_MIN_LAG;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset lags 1..16: extremes, lags past the count, single and constant series
		dir = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8000,
		        16'sh7fff, 16'sh5555};
		send_vals(dir);
		dir = '{16'sh8000};
		send_vals(dir);
		dir = '{16'sh0007, 16'sh0007, 16'sh0007};
		send_vals(dir);
		dir = '{16'sh0064, -16'sh0064};
		send_vals(dir);

		// bad lag settings, one error word each
		wait_idle();
		write_reg(sacl_pkg::CFG_MIN_LAG, 7'd0);
		dir = '{16'sh0005, 16'sh0009};
		send_vals(dir);
		wait_idle();
		write_reg(sacl_pkg::CFG_MIN_LAG, 7'd3);
		write_reg(sacl_pkg::CFG_MAX_LAG, 7'd3);
		dir = '{-16'sh0003};
		send_vals(dir);
		wait_idle();
		write_reg(sacl_pkg::CFG_MIN_LAG, 7'd2);
		write_reg(sacl_pkg::CFG_MAX_LAG, 7'd127);
		dir = '{16'sh0001, -16'sh0002};
		send_vals(dir);
		wait_idle();
		write_reg(sacl_pkg::CFG_MIN_LAG, 7'd20);
		write_reg(sacl_pkg::CFG_MAX_LAG, 7'd10);
		dir = '{16'sh0000};
		send_vals(dir);

		// widest lag span; bit 6 of min_lag data falls off the 6-bit register
		wait_idle();
		write_reg(sacl_pkg::CFG_MIN_LAG, 7'd65);
		write_reg(sacl_pkg::CFG_MAX_LAG, 7'd64);
		send_series(66, SER_FULL, 0);
		wait_idle();
		write_reg(sacl_pkg::CFG_MIN_LAG, 7'd63);
		send_series(10, SER_EXTREME, 0);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
				0: begin
					lo = 0;
					hi = $urandom_range(1, 64);
				end
				1: begin
					lo = $urandom_range(1, 63);
					hi = $urandom_range(65, 127);
				end
				default: begin
					lo = $urandom_range(1, 63);
					hi = $urandom_range(1, lo);
				end
				endcase
			end else begin
				lo = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
				if ($urandom_range(0, 1))
					hi = $urandom_range(lo + 1, 64);
				else
					hi = lo + 1 + $urandom_range(0, 5);
				if (hi > 64)
					hi = 64;
			end
			write_reg(sacl_pkg::CFG_MIN_LAG, CFG_DATA_W'(lo));
			write_reg(sacl_pkg::CFG_MAX_LAG, CFG_DATA_W'(hi));
			burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 2)) begin
				case ($urandom_range(0, 9))
				0:       len = 1;
				1:       len = $urandom_range(20, 40);
				default: len = $urandom_range(2, 16);
				endcase
				case ($urandom_range(0, 9))
				0, 1:    kind = SER_SMALL;
				2:       kind = SER_CONST;
				3:       kind = SER_EXTREME;
				default: kind = SER_FULL;
				endcase
				send_series(len, kind, burst);
				sent += len;
				// hold the next series back until the lag words have all come
				if ($urandom_range(0, 3) == 0)
					wait_results();
			end
		end

		wait_results();
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
